### rtl/core/far_end_echo_gate_defines.svh
// Assertion macros used by the echo gate top level.
`ifndef FAR_END_ECHO_GATE_DEFINES_SVH
`define FAR_END_ECHO_GATE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FEEG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define FEEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/feeg_pkg.sv
// Shared widths, constants and operation codes of the echo gate.
`timescale 1ns / 1ps
package feeg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 13;
    localparam int GAIN_W     = 17;
    localparam int LEVEL_W    = 16;
    localparam int HANG_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int SUM_W      = 43;
    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int MUL_AW     = 17;
    localparam int MUL_BW     = 17;
    localparam int GAIN_SHIFT = 12;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY = GAIN_W'(1 << GAIN_SHIFT);
    localparam logic [FRAME_W-1:0] MAX_FRAME  = FRAME_W'(4096);

    // Register indexes on the APB port.
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_SHUT_GAIN   = 2'd1;
    localparam logic [1:0] REG_HOLD_FRAMES = 2'd2;

    typedef enum logic [1:0] {
        OP_FAR    = 2'd0,
        OP_SILENT = 2'd1,
        OP_NEAR   = 2'd2
    } op_t;

endpackage

### rtl/core/feeg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module feeg_mul #(
    parameter int AW = feeg_pkg::MUL_AW,
    parameter int BW = feeg_pkg::MUL_BW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            done,
    output logic [AW+BW-1:0] product
);

    localparam int CNT_W = (BW > 1) ? $clog2(BW) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [AW-1:0]     mcand_reg;
    logic [AW-1:0]     hi_reg;
    logic [BW-1:0]     lo_reg;
    logic [AW:0]       step_sum;

    // Add the multiplicand when the current multiplier bit is set, then shift right.
    assign step_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            hi_reg    <= '0;
            lo_reg    <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= step_sum[AW:1];
            lo_reg <= {step_sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

### rtl/core/feeg_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module feeg_div #(
    parameter int NW = feeg_pkg::SUM_W,
    parameter int DW = feeg_pkg::FRAME_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      trial;
    logic [DW:0]      trial_diff;
    logic             fits;

    assign trial      = {rem_reg, quo_reg[NW-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/feeg_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module feeg_sqrt #(
    parameter int IW = feeg_pkg::SUM_W,
    parameter int RW = (IW + 1) / 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [IW-1:0] radicand,
    output logic          done,
    output logic [RW-1:0] root
);

    localparam int CNT_W = (RW > 1) ? $clog2(RW) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*RW-1:0]  rad_reg;
    logic [RW:0]      rem_reg;
    logic [RW-1:0]    root_reg;
    logic [RW+2:0]    trial;
    logic [RW+2:0]    probe;
    logic [RW+2:0]    trial_diff;
    logic             fits;

    // Bring down the next two radicand bits and test (4*root + 1).
    assign trial      = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign probe      = {1'b0, root_reg, 2'b01};
    assign fits       = trial >= probe;
    assign trial_diff = trial - probe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= (2*RW)'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= fits ? trial_diff[RW:0] : trial[RW:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/far_end_echo_gate.sv
// Top level of the far-end echo gate: control sequencer, state and ports.
//
//  channel  | direction | transaction contents
//  s_axis   | in        | tuser op, tdata sample/frame_samples, tlast end of frame
//  m_axis   | out       | tuser gain_applied, tdata sample_out/level/hang/closures
//  apb      | in/out    | threshold, shut gain, hold frames at 0x0, 0x4, 0x8
//
// One item at a time: input is ready only while idle, and a stalled output holds the item.
// A far sample runs a serial 17-bit square; the last far sample adds a
// divide and a square root after it.
// A ramped near sample runs multiply, divide, multiply in series.
// Passed near samples, silent events and unknown operations use no arithmetic unit.
// rst_n clears all control state at once; a full output register holds the result state.
`timescale 1ns / 1ps
`include "far_end_echo_gate_defines.svh"
module far_end_echo_gate (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] sample, [28:16] frame_samples
    input  logic [1:0]  s_axis_tuser,  // [1:0] operation
    input  logic        s_axis_tlast,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [15:0] sample_out, [31:16] far_level,
                                       // [32] hang_active, [64:33] closure_count
    output logic        m_axis_tuser   // [0] gain_applied
);

    localparam int SW  = feeg_pkg::SAMPLE_W;
    localparam int FW  = feeg_pkg::FRAME_W;
    localparam int GW  = feeg_pkg::GAIN_W;
    localparam int LW  = feeg_pkg::LEVEL_W;
    localparam int HW  = feeg_pkg::HANG_W;
    localparam int CW  = feeg_pkg::COUNT_W;
    localparam int UW  = feeg_pkg::SUM_W;
    localparam int RW  = feeg_pkg::ROOT_W;
    localparam int AW  = feeg_pkg::MUL_AW;
    localparam int BW  = feeg_pkg::MUL_BW;
    localparam int PW  = AW + BW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LVL_DIV,
        ST_LVL_ROOT,
        ST_NEAR,
        ST_RAMP_MUL,
        ST_RAMP_DIV,
        ST_SCALE,
        ST_RESULT
    } state_t;

    // configuration
    logic [LW-1:0] threshold_reg;
    logic [GW-1:0] shut_gain_reg;
    logic [HW-1:0] hold_frames_reg;
    logic          cfg_write;

    // control and state
    state_t        state_reg, state_next;
    logic [SW-1:0] sample_reg, sample_next;
    logic [FW-1:0] len_reg, len_next;
    logic          last_reg, last_next;
    logic [UW-1:0] square_sum_reg, square_sum_next;
    logic [FW-1:0] frame_index_reg, frame_index_next;
    logic [LW-1:0] level_reg, level_next;
    logic [HW-1:0] hang_count_reg, hang_count_next;
    logic [GW-1:0] ramp_start_reg, ramp_start_next;
    logic [GW-1:0] ramp_target_reg, ramp_target_next;
    logic [CW-1:0] closures_reg, closures_next;
    logic          diff_neg_reg, diff_neg_next;
    logic [SW-1:0] res_sample_reg, res_sample_next;
    logic          res_applied_reg, res_applied_next;
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] out_sample_reg, out_sample_next;
    logic          out_applied_reg, out_applied_next;
    logic [LW-1:0] out_level_reg, out_level_next;
    logic          out_hang_reg, out_hang_next;
    logic [CW-1:0] out_closures_reg, out_closures_next;

    // arithmetic units
    logic          mul_start, mul_done;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_prod;
    logic          div_start, div_done;
    logic [UW-1:0] div_num, div_quo;
    logic [FW-1:0] div_den;
    logic          sqrt_start, sqrt_done;
    logic [UW-1:0] sqrt_rad;
    logic [RW-1:0] sqrt_root;

    // helpers
    logic [FW-1:0] in_len_raw, in_len;
    logic          in_accept;
    logic [SW-1:0] abs_sample;
    logic [UW:0]   sum_wide;
    logic [UW-1:0] sum_sat;
    logic [LW-1:0] root_sat;
    logic [LW-1:0] decide_lvl;
    logic          loud;
    logic [HW-1:0] hang_decided;
    logic [CW-1:0] closures_decided;
    logic [FW-1:0] index_advanced;
    logic [GW-1:0] near_target, eff_start, eff_target;
    logic [GW:0]   ramp_diff;
    logic [GW-1:0] diff_mag;
    logic [FW:0]   pos_wide;
    logic [FW-1:0] pos_clamped;
    logic [GW:0]   gain_wide;
    logic [PW-1:0] scaled_mag;
    logic [SW-1:0] scaled_sat;
    logic          load_out;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= '0;
            shut_gain_reg   <= feeg_pkg::GAIN_UNITY;
            hold_frames_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                feeg_pkg::REG_THRESHOLD:   threshold_reg   <= pwdata[LW-1:0];
                feeg_pkg::REG_SHUT_GAIN:   shut_gain_reg   <= pwdata[GW-1:0];
                feeg_pkg::REG_HOLD_FRAMES: hold_frames_reg <= pwdata[HW-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            feeg_pkg::REG_THRESHOLD:   prdata = 32'(threshold_reg);
            feeg_pkg::REG_SHUT_GAIN:   prdata = 32'(shut_gain_reg);
            feeg_pkg::REG_HOLD_FRAMES: prdata = 32'(hold_frames_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- shared serial units ----------------
    feeg_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    feeg_div #(
        .NW (UW),
        .DW (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .denom    (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    feeg_sqrt #(
        .IW (UW),
        .RW (RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------- datapath helpers ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Clamp frame length to 1..MAX_FRAME.
    assign in_len_raw = s_axis_tdata[SW+FW-1:SW];
    assign in_len     = (in_len_raw == '0) ? FW'(1) :
                        (in_len_raw > feeg_pkg::MAX_FRAME) ? feeg_pkg::MAX_FRAME : in_len_raw;

    assign abs_sample = sample_reg[SW-1] ? (~sample_reg + 1'b1) : sample_reg;

    // Saturate the running sum of squares.
    assign sum_wide = {1'b0, square_sum_reg} + (UW+1)'(mul_prod);
    assign sum_sat  = sum_wide[UW] ? {UW{1'b1}} : sum_wide[UW-1:0];

    assign root_sat = (sqrt_root > RW'({LW{1'b1}})) ? {LW{1'b1}} : sqrt_root[LW-1:0];

    // Hang decision for a finished far frame or a silent event.
    assign decide_lvl       = (state_reg == ST_LVL_ROOT) ? root_sat : '0;
    assign loud             = decide_lvl >= threshold_reg;
    assign hang_decided     = loud ? hold_frames_reg :
                              (hang_count_reg != '0) ? hang_count_reg - 1'b1 : hang_count_reg;
    assign closures_decided = closures_reg + CW'(loud && (hang_count_reg == '0));

    assign index_advanced = last_reg ? '0 :
                            (frame_index_reg != {FW{1'b1}}) ? frame_index_reg + 1'b1 :
                            frame_index_reg;

    // Ramp endpoints; the current gain always equals the last target.
    assign near_target = (hang_count_reg != '0) ? shut_gain_reg : feeg_pkg::GAIN_UNITY;
    assign eff_start   = (frame_index_reg == '0) ? ramp_target_reg : ramp_start_reg;
    assign eff_target  = (frame_index_reg == '0) ? near_target : ramp_target_reg;
    assign ramp_diff   = {1'b0, eff_target} - {1'b0, eff_start};
    assign diff_mag    = ramp_diff[GW] ? GW'(~ramp_diff + 1'b1) : ramp_diff[GW-1:0];
    assign pos_wide    = {1'b0, frame_index_reg} + 1'b1;
    assign pos_clamped = (pos_wide > {1'b0, len_reg}) ? len_reg : pos_wide[FW-1:0];

    assign gain_wide = diff_neg_reg ? ({1'b0, ramp_start_reg} - (GW+1)'(div_quo[GW-1:0])) :
                                      ({1'b0, ramp_start_reg} + (GW+1)'(div_quo[GW-1:0]));

    // Truncate toward zero on the magnitude, then saturate with the sign.
    assign scaled_mag = mul_prod >> feeg_pkg::GAIN_SHIFT;
    assign scaled_sat = sample_reg[SW-1] ?
                        ((scaled_mag > PW'(1 << (SW-1))) ? {1'b1, {(SW-1){1'b0}}} :
                                                            (~scaled_mag[SW-1:0] + 1'b1)) :
                        ((scaled_mag > PW'((1 << (SW-1)) - 1)) ? {1'b0, {(SW-1){1'b1}}} :
                                                                  scaled_mag[SW-1:0]);

    assign load_out = (state_reg == ST_RESULT) && (!out_valid_reg || m_axis_tready);

    function automatic logic [SW-1:0] abs_value(input logic [SW-1:0] v);
        abs_value = v[SW-1] ? (~v + 1'b1) : v;
    endfunction

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        sample_next       = sample_reg;
        len_next          = len_reg;
        last_next         = last_reg;
        square_sum_next   = square_sum_reg;
        frame_index_next  = frame_index_reg;
        level_next        = level_reg;
        hang_count_next   = hang_count_reg;
        ramp_start_next   = ramp_start_reg;
        ramp_target_next  = ramp_target_reg;
        closures_next     = closures_reg;
        diff_neg_next     = diff_neg_reg;
        res_sample_next   = res_sample_reg;
        res_applied_next  = res_applied_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_sample_next   = out_sample_reg;
        out_applied_next  = out_applied_reg;
        out_level_next    = out_level_reg;
        out_hang_next     = out_hang_reg;
        out_closures_next = out_closures_reg;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;
        div_num           = '0;
        div_den           = '0;
        sqrt_start        = 1'b0;
        sqrt_rad          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next      = s_axis_tdata[SW-1:0];
                    len_next         = in_len;
                    last_next        = s_axis_tlast;
                    res_sample_next  = '0;
                    res_applied_next = 1'b0;
                    unique case (feeg_pkg::op_t'(s_axis_tuser))
                        feeg_pkg::OP_FAR:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = AW'(abs_value(s_axis_tdata[SW-1:0]));
                            mul_b      = BW'(abs_value(s_axis_tdata[SW-1:0]));
                            state_next = ST_SQUARE;
                        end
                        feeg_pkg::OP_SILENT:
                        begin
                            level_next       = '0;
                            hang_count_next  = hang_decided;
                            closures_next    = closures_decided;
                            square_sum_next  = '0;
                            frame_index_next = '0;
                            state_next       = ST_RESULT;
                        end
                        feeg_pkg::OP_NEAR:
                        begin
                            state_next = ST_NEAR;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    if (last_reg)
                    begin
                        div_start       = 1'b1;
                        div_num         = sum_sat;
                        div_den         = len_reg;
                        square_sum_next = '0;
                        state_next      = ST_LVL_DIV;
                    end
                    else
                    begin
                        square_sum_next  = sum_sat;
                        frame_index_next = index_advanced;
                        state_next       = ST_RESULT;
                    end
                end
            end

            ST_LVL_DIV:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    sqrt_rad   = div_quo;
                    state_next = ST_LVL_ROOT;
                end
            end

            ST_LVL_ROOT:
            begin
                if (sqrt_done)
                begin
                    level_next       = root_sat;
                    hang_count_next  = hang_decided;
                    closures_next    = closures_decided;
                    frame_index_next = '0;
                    state_next       = ST_RESULT;
                end
            end

            ST_NEAR:
            begin
                ramp_start_next  = eff_start;
                ramp_target_next = eff_target;
                if (eff_start == feeg_pkg::GAIN_UNITY && eff_target == feeg_pkg::GAIN_UNITY)
                begin
                    res_sample_next  = sample_reg;
                    frame_index_next = index_advanced;
                    state_next       = ST_RESULT;
                end
                else
                begin
                    diff_neg_next = ramp_diff[GW];
                    mul_start     = 1'b1;
                    mul_a         = AW'(diff_mag);
                    mul_b         = BW'(pos_clamped);
                    state_next    = ST_RAMP_MUL;
                end
            end

            ST_RAMP_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = UW'(mul_prod);
                    div_den    = len_reg;
                    state_next = ST_RAMP_DIV;
                end
            end

            ST_RAMP_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = AW'(abs_sample);
                    mul_b      = BW'(gain_wide[GW-1:0]);
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE:
            begin
                if (mul_done)
                begin
                    res_sample_next  = scaled_sat;
                    res_applied_next = 1'b1;
                    frame_index_next = index_advanced;
                    state_next       = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (load_out)
                begin
                    out_valid_next    = 1'b1;
                    out_sample_next   = res_sample_reg;
                    out_applied_next  = res_applied_reg;
                    out_level_next    = level_reg;
                    out_hang_next     = (hang_count_reg != '0);
                    out_closures_next = closures_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            square_sum_reg  <= '0;
            frame_index_reg <= '0;
            level_reg       <= '0;
            hang_count_reg  <= '0;
            ramp_start_reg  <= feeg_pkg::GAIN_UNITY;
            ramp_target_reg <= feeg_pkg::GAIN_UNITY;
            closures_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            square_sum_reg  <= square_sum_next;
            frame_index_reg <= frame_index_next;
            level_reg       <= level_next;
            hang_count_reg  <= hang_count_next;
            ramp_start_reg  <= ramp_start_next;
            ramp_target_reg <= ramp_target_next;
            closures_reg    <= closures_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg       <= sample_next;
        len_reg          <= len_next;
        last_reg         <= last_next;
        diff_neg_reg     <= diff_neg_next;
        res_sample_reg   <= res_sample_next;
        res_applied_reg  <= res_applied_next;
        out_sample_reg   <= out_sample_next;
        out_applied_reg  <= out_applied_next;
        out_level_reg    <= out_level_next;
        out_hang_reg     <= out_hang_next;
        out_closures_reg <= out_closures_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_applied_reg;
    assign m_axis_tdata  = {7'b0, out_closures_reg, out_hang_reg, out_level_reg, out_sample_reg};

    // ---------------- assertions ----------------
    `FEEG_ASSERT_NEXT(a_one_item_at_a_time, in_accept, !s_axis_tready,
        "input accepted while an item is still in work")
    `FEEG_ASSERT_NEXT(a_no_closure_while_hung, hang_count_reg != '0,
        closures_reg == $past(closures_reg), "closure counted while hang counter nonzero")
    `FEEG_ASSERT_SAME(a_root_after_divide, sqrt_start, div_done && state_reg == ST_LVL_DIV,
        "square root started without a finished level divide")

endmodule

### tb/sv/far_end_echo_gate_tb.sv
// Self-checking testbench for the far-end echo gate: stream stimulus, APB setup, output check.
`timescale 1ns / 1ps
module far_end_echo_gate_tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    // Budget for the slowest item, the longest sender gap and a long stall
    // for roughly 2k items, then take that several times over.
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int RANDOM_PHASES = 7;
    localparam int LONG_RUN      = 60;
    localparam int SETTLE_CYCLES = 200;
    localparam int REPORT_CAP    = 40;

    localparam logic [1:0]  OP_RESERVED = 2'd3;
    localparam logic [42:0] SUM_CEIL    = '1;
    localparam logic [12:0] INDEX_CEIL  = '1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] sample;
        logic [12:0] frame_samples;
        logic        last;
    } gate_item_t;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        gain_applied;
        logic [15:0] far_level;
        logic        hang_active;
        logic [31:0] closure_count;
    } gate_result_t;

    class gate_scoreboard;
        logic [15:0] threshold_cfg;
        logic [16:0] shut_gain_cfg;
        logic [15:0] hang_reload_cfg;

        logic [42:0] energy_sum;
        logic [12:0] frame_pos;
        logic [15:0] level;
        logic [15:0] hang_left;
        logic [16:0] gain_now;
        logic [16:0] ramp_from;
        logic [16:0] ramp_to;
        logic [31:0] closures;

        gate_result_t awaited_outputs[$];
        int mismatches;
        int checked;
        int scaled;

        function new();
            threshold_cfg   = '0;
            shut_gain_cfg   = feeg_pkg::GAIN_UNITY;
            hang_reload_cfg = '0;
            energy_sum      = '0;
            frame_pos       = '0;
            level           = '0;
            hang_left       = '0;
            gain_now        = feeg_pkg::GAIN_UNITY;
            ramp_from       = feeg_pkg::GAIN_UNITY;
            ramp_to         = feeg_pkg::GAIN_UNITY;
            closures        = '0;
            mismatches      = 0;
            checked         = 0;
            scaled          = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                feeg_pkg::REG_THRESHOLD:   threshold_cfg   = value[15:0];
                feeg_pkg::REG_SHUT_GAIN:   shut_gain_cfg   = value[16:0];
                feeg_pkg::REG_HOLD_FRAMES: hang_reload_cfg = value[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            // Sums stay below 2^43, so the root fits in 22 bits.
            for (int b = 21; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function void judge_far_level();
            if (level >= threshold_cfg) begin
                if (hang_left == 0)
                    closures++;
                hang_left = hang_reload_cfg;
            end
            else if (hang_left != 0) begin
                hang_left--;
            end
        endfunction

        function void advance_frame(logic last);
            if (last)
                frame_pos = '0;
            else if (frame_pos != INDEX_CEIL)
                frame_pos++;
        endfunction

        function gate_result_t gated_output(gate_item_t it);
            longint          s;
            longint          g;
            longint          r;
            longint unsigned sq;
            longint unsigned total;
            longint unsigned len;
            longint unsigned pos;
            longint unsigned root;
            gate_result_t    res;
            s   = longint'(signed'(it.sample));
            len = (it.frame_samples == '0) ? 1 :
                  (it.frame_samples > feeg_pkg::MAX_FRAME) ? feeg_pkg::MAX_FRAME :
                  it.frame_samples;
            res.sample_out   = '0;
            res.gain_applied = 1'b0;
            case (it.op)
                feeg_pkg::OP_FAR: begin
                    sq    = s * s;
                    total = energy_sum + sq;
                    energy_sum = (total > SUM_CEIL) ? SUM_CEIL : total[42:0];
                    if (it.last) begin
                        root  = floor_root(energy_sum / len);
                        level = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
                        judge_far_level();
                        energy_sum = '0;
                    end
                    advance_frame(it.last);
                end
                feeg_pkg::OP_SILENT: begin
                    level = '0;
                    judge_far_level();
                    energy_sum = '0;
                    frame_pos  = '0;
                end
                feeg_pkg::OP_NEAR: begin
                    if (frame_pos == '0) begin
                        ramp_from = gain_now;
                        ramp_to   = (hang_left != 0) ? shut_gain_cfg : feeg_pkg::GAIN_UNITY;
                        gain_now  = ramp_to;
                    end
                    if (ramp_from == feeg_pkg::GAIN_UNITY && ramp_to == feeg_pkg::GAIN_UNITY)
                    begin
                        res.sample_out = it.sample;
                    end
                    else begin
                        // Hold the target once the position runs past the frame length.
                        pos = frame_pos + 1;
                        if (pos > len)
                            pos = len;
                        g = longint'(ramp_from) + (longint'(ramp_to) - longint'(ramp_from))
                            * longint'(pos) / longint'(len);
                        r = s * g / longint'(feeg_pkg::GAIN_UNITY);
                        if (r > 32767)
                            r = 32767;
                        if (r < -32768)
                            r = -32768;
                        res.sample_out   = r[15:0];
                        res.gain_applied = 1'b1;
                    end
                    advance_frame(it.last);
                end
                default: ;
            endcase
            res.far_level     = level;
            res.hang_active   = (hang_left != 0);
            res.closure_count = closures;
            return res;
        endfunction

        function void note_input(gate_item_t it);
            awaited_outputs.push_back(gated_output(it));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_output(gate_result_t got);
            gate_result_t want;
            if (awaited_outputs.size() == 0) begin
                report_mismatch($sformatf("output transaction %h with nothing pending", got));
                return;
            end
            want = awaited_outputs.pop_front();
            checked++;
            if (got.gain_applied)
                scaled++;
            if (got.sample_out !== want.sample_out)
                report_mismatch($sformatf("output %0d sample_out %h, want %h",
                                          checked, got.sample_out, want.sample_out));
            if (got.gain_applied !== want.gain_applied)
                report_mismatch($sformatf("output %0d gain_applied %b, want %b",
                                          checked, got.gain_applied, want.gain_applied));
            if (got.far_level !== want.far_level)
                report_mismatch($sformatf("output %0d far_level %0d, want %0d",
                                          checked, got.far_level, want.far_level));
            if (got.hang_active !== want.hang_active)
                report_mismatch($sformatf("output %0d hang_active %b, want %b",
                                          checked, got.hang_active, want.hang_active));
            if (got.closure_count !== want.closure_count)
                report_mismatch($sformatf("output %0d closure_count %0d, want %0d",
                                          checked, got.closure_count, want.closure_count));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [15:0] sample, [28:16] frame_samples
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] operation
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [15:0] sample_out, [31:16] far_level,
                                      // [32] hang_active, [64:33] closure_count
    logic        m_axis_tuser;        // [0] gain_applied

    gate_scoreboard board;
    int items_sent;
    int burst_left;
    int settings_used;
    int cycle_count;
    int ready_mode;
    int mode_left;
    int run_left;
    logic ready_level = 1'b0;

    far_end_echo_gate DUT (.*);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Receiver: switch between always ready, random stalls and long stall runs.
    always @(negedge clk)
    begin
        if (mode_left <= 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(100, 800);
        end
        mode_left--;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left <= 0) begin
                    ready_level = !ready_level;
                    run_left    = ready_level ? $urandom_range(1, 10) : $urandom_range(1, 40);
                end
                run_left--;
                m_axis_tready <= ready_level;
            end
        endcase
    end

    always @(posedge clk)
    begin : output_monitor
        gate_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sample_out    = m_axis_tdata[15:0];
            got.far_level     = m_axis_tdata[31:16];
            got.hang_active   = m_axis_tdata[32];
            got.closure_count = m_axis_tdata[64:33];
            got.gain_applied  = m_axis_tuser;
            board.check_output(got);
        end
    end

    task automatic send_item(logic [1:0] op, logic [15:0] sample, logic [12:0] fs,
                             logic last);
        int k;
        int gap;
        gate_item_t it;
        if (burst_left <= 0) begin
            k   = $urandom_range(0, 9);
            gap = (k < 5) ? 0 : (k < 7) ? $urandom_range(1, 4) :
                  (k < 9) ? $urandom_range(5, 30) : $urandom_range(31, 120);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, fs, sample};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        it = '{op, sample, fs, last};
        board.note_input(it);
        if (op != OP_RESERVED)
            items_sent++;
    endtask

    // Hold the input idle until every pending output has arrived.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.awaited_outputs.size() != 0) @(posedge clk);
    endtask

    task automatic apb_access(logic write, int idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= 4'(4 * idx);
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (write)
            board.set_register(idx, wdata);
    endtask

    task automatic check_register(int idx, logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want)
            board.report_mismatch($sformatf("register %0d reads %h, want %h", idx, rd, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [15:0] thr, logic [16:0] cg, logic [15:0] hf);
        logic [31:0] rd;
        apb_access(1'b1, feeg_pkg::REG_THRESHOLD, 32'(thr), rd);
        check_register(feeg_pkg::REG_THRESHOLD, 32'(thr));
        apb_access(1'b1, feeg_pkg::REG_SHUT_GAIN, 32'(cg), rd);
        check_register(feeg_pkg::REG_SHUT_GAIN, 32'(cg));
        apb_access(1'b1, feeg_pkg::REG_HOLD_FRAMES, 32'(hf), rd);
        check_register(feeg_pkg::REG_HOLD_FRAMES, 32'(hf));
        settings_used++;
    endtask

    function automatic logic [15:0] rand_sample(int amp);
        int v;
        if (amp >= 32767)
            return 16'($urandom);
        v = $urandom_range(0, 2 * amp);
        return 16'(v - amp);
    endfunction

    task automatic send_directed();
        // Pass-through at both sample extremes, then a loud far frame closes the gate.
        send_item(feeg_pkg::OP_NEAR, 16'h7FFF, 13'd1, 1'b1);
        send_item(feeg_pkg::OP_NEAR, 16'h8000, 13'd1, 1'b1);
        send_item(feeg_pkg::OP_FAR, 16'h7FFF, 13'd1, 1'b1);
        // Ramp down from unity toward the shut gain.
        send_item(feeg_pkg::OP_NEAR, 16'h7FFF, 13'd3, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'h8000, 13'd3, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'd1000, 13'd3, 1'b1);
        // Silent event with junk fields, then a quiet frame releases the hang.
        send_item(feeg_pkg::OP_SILENT, 16'hFFFF, 13'h1FFF, 1'b0);
        send_item(feeg_pkg::OP_FAR, 16'd5, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_FAR, 16'hFFFB, 13'd2, 1'b1);
        // Ramp back up, then a unity frame.
        send_item(feeg_pkg::OP_NEAR, 16'hFB2E, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'd2345, 13'd2, 1'b1);
        send_item(feeg_pkg::OP_NEAR, 16'h0001, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'hFFFF, 13'd2, 1'b1);
        send_item(OP_RESERVED, 16'hA5A5, 13'h1555, 1'b1);
        // Zero length clamps to one: the level overflows and saturates.
        repeat (4) send_item(feeg_pkg::OP_FAR, 16'h8000, 13'd0, 1'b0);
        send_item(feeg_pkg::OP_FAR, 16'h8000, 13'd0, 1'b1);
        // Frame longer than its stated length holds the target gain.
        send_item(feeg_pkg::OP_NEAR, 16'h4000, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'hC000, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'h7FFF, 13'd2, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'h8000, 13'd2, 1'b1);
        // Oversized length clamps to the maximum frame.
        send_item(feeg_pkg::OP_NEAR, 16'h1234, 13'h1FFF, 1'b1);
    endtask

    task automatic send_random(int n_items);
        int target;
        int kind;
        int len;
        int pick;
        int amp;
        logic drop_last;
        logic [1:0] op;
        logic [12:0] fs;
        target = items_sent + n_items;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
            pick = $urandom_range(0, 19);
            fs   = (pick < 15) ? 13'(len) : (pick < 17) ? 13'($urandom_range(0, 8191)) :
                   (pick < 19) ? 13'($urandom_range(1, len)) : feeg_pkg::MAX_FRAME;
            case ($urandom_range(0, 2))
                0: amp = 40;
                1: amp = 1500;
                default: amp = 32767;
            endcase
            if (kind < 40 || (kind >= 50 && kind < 92)) begin
                op        = (kind < 40) ? feeg_pkg::OP_FAR : feeg_pkg::OP_NEAR;
                drop_last = ($urandom_range(0, 19) == 0);
                for (int i = 0; i < len; i++)
                    send_item(op, rand_sample(amp), fs, (i == len - 1) && !drop_last);
            end
            else if (kind < 50) begin
                send_item(feeg_pkg::OP_SILENT, 16'($urandom), 13'($urandom), 1'($urandom));
            end
            else begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom), 16'($urandom), 13'($urandom), 1'($urandom));
            end
        end
    endtask

    // Run one long loud far frame with no end mark, mix in near samples, then close it.
    task automatic send_long_run();
        for (int i = 0; i < LONG_RUN; i++)
            send_item(feeg_pkg::OP_FAR, 16'h8000, 13'($urandom), 1'b0);
        repeat (3)
            send_item(feeg_pkg::OP_NEAR, 16'($urandom), 13'($urandom_range(1, 16)), 1'b0);
        send_item(feeg_pkg::OP_FAR, 16'h8000, 13'd0, 1'b1);
        send_item(feeg_pkg::OP_NEAR, 16'h7FFF, 13'd3, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'h8000, 13'd3, 1'b0);
        send_item(feeg_pkg::OP_NEAR, 16'($urandom), 13'd3, 1'b1);
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("** far_end_echo_gate: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        board         = new();
        items_sent    = 0;
        burst_left    = 0;
        settings_used = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_register(feeg_pkg::REG_THRESHOLD, 32'd0);
        check_register(feeg_pkg::REG_SHUT_GAIN, 32'(feeg_pkg::GAIN_UNITY));
        check_register(feeg_pkg::REG_HOLD_FRAMES, 32'd0);

        configure(16'd1000, 17'd1024, 16'd2);
        send_directed();
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd0, 17'd65536, 16'd65535);
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd65535, 17'd0, 16'd0);
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd500, 17'd0, 16'd1);
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd2000, 17'd8192, 16'd3);
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'($urandom_range(0, 3000)), 17'($urandom_range(0, 65536)),
                  16'($urandom_range(0, 8)));
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd1500, feeg_pkg::GAIN_UNITY, 16'd4);
        send_random(RANDOM_ITEMS / RANDOM_PHASES);
        drain();
        configure(16'd65535, 17'd8192, 16'd5);
        send_long_run();
        drain();

        // Catch any output that shows up with nothing pending.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d items under %0d register settings; %0d outputs checked",
                 items_sent, settings_used, board.checked);
        $display("  %0d near outputs scaled, %0d gate closures, one long unterminated frame",
                 board.scaled, board.closures);
        if (board.mismatches == 0)
            $display("** far_end_echo_gate: PASSED **");
        else
            $display("** far_end_echo_gate: FAILED **");
        $finish;
    end
endmodule
